### hw/rtl/mte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mte_pkg
// Shared types and constants for the MIDI track event encoder.
// ----------------------------------------------------------------------------
package mte_pkg;

  localparam logic CMD_NOTE = 1'b0;
  localparam logic CMD_EOT  = 1'b1;

  localparam logic [7:0] META_PREFIX = 8'hFF;
  localparam logic [7:0] META_EOT    = 8'h2F;
  localparam logic [7:0] ZERO_BYTE   = 8'h00;

  localparam int GRP_BITS  = 7;
  localparam int MAX_GRPS  = 5;
  localparam int DLY_BITS  = GRP_BITS * MAX_GRPS;

  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [2:0] EOT_LAST_IDX = 3'd3;

  // One classified request, queued between front and back
  typedef struct packed {
    logic                cmd;
    logic [2:0]          ngrp;
    logic [DLY_BITS-1:0] dly;
    logic [6:0]          key;
    logic [6:0]          vel;
    logic                is_on;
  } entry_t;

  // Queue handshake seen by a consumer
  typedef struct packed {
    logic   valid;
    entry_t data;
  } q_out_t;

endpackage

### hw/rtl/mte_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mte_front
// Accepts requests, computes the tick delta and its VLQ group count.
// ----------------------------------------------------------------------------
module mte_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_cmd,
  input  logic [31:0]     in_event_tick,
  input  logic [6:0]      in_note_key,
  input  logic [6:0]      in_note_velocity,
  input  logic            in_is_on,
  input  logic            q_full,
  output logic            q_push,
  output mte_pkg::entry_t q_data
);

  logic [31:0] last_tick_r, last_tick_nxt;
  logic [31:0] delta;
  logic [2:0]  ngrp;
  logic [mte_pkg::DLY_BITS-1:0] dly_ext;
  logic [mte_pkg::DLY_BITS-1:0] dly_al;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign delta    = in_event_tick - last_tick_r;
  assign dly_ext  = {{(mte_pkg::DLY_BITS-32){1'b0}}, delta};

  always_comb begin
    if (delta[31:28] != '0) begin
      ngrp = 3'd5;
    end else if (delta[27:21] != '0) begin
      ngrp = 3'd4;
    end else if (delta[20:14] != '0) begin
      ngrp = 3'd3;
    end else if (delta[13:7] != '0) begin
      ngrp = 3'd2;
    end else begin
      ngrp = 3'd1;
    end
  end

  // left-align so the leading group sits in the top seven bits
  always_comb begin
    unique case (ngrp)
      3'd5:    dly_al = dly_ext;
      3'd4:    dly_al = dly_ext << 7;
      3'd3:    dly_al = dly_ext << 14;
      3'd2:    dly_al = dly_ext << 21;
      default: dly_al = dly_ext << 28;
    endcase
  end

  always_comb begin
    q_data.cmd   = in_cmd;
    q_data.ngrp  = ngrp;
    q_data.dly   = dly_al;
    q_data.key   = in_note_key;
    q_data.vel   = in_note_velocity;
    q_data.is_on = in_is_on;
  end

  always_comb begin
    last_tick_nxt = last_tick_r;
    if (q_push) begin
      last_tick_nxt = (in_cmd == mte_pkg::CMD_EOT) ? 32'd0 : in_event_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_tick_r <= '0;
    end else begin
      last_tick_r <= last_tick_nxt;
    end
  end

  a_eot_clears_tick: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && in_cmd == mte_pkg::CMD_EOT |=> last_tick_r == 32'd0)
    else $error("end of track did not clear last tick");
  a_grp_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> ngrp >= 3'd1 && ngrp <= 3'd5)
    else $error("group count out of range");
  a_short_delta: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && delta <= 32'd127 |-> ngrp == 3'd1)
    else $error("short delta not single byte");

endmodule

### hw/rtl/mte_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mte_queue
// Small request queue decoupling the front from the byte serializer.
// ----------------------------------------------------------------------------
module mte_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mte_pkg::entry_t din,
  output logic            full,
  input  logic            pop,
  output mte_pkg::q_out_t qout
);

  mte_pkg::entry_t ent_r [mte_pkg::Q_DEPTH];
  logic [mte_pkg::Q_PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [mte_pkg::Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign full       = (cnt_r == mte_pkg::Q_CNT_W'(mte_pkg::Q_DEPTH));
  assign qout.valid = (cnt_r != '0);
  assign qout.data  = ent_r[rp_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && qout.valid;

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= din;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mte_pkg::Q_CNT_W'(mte_pkg::Q_DEPTH))
    else $error("queue count overflow");
  a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || full) |-> wp_r == rp_r)
    else $error("queue pointers disagree with count");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !do_push)
    else $error("push into full queue");

endmodule

### hw/rtl/mte_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mte_back
// Serializes queued requests into track bytes, one per cycle unless
// out_ready stalls the output, and keeps the running track byte count.
// ----------------------------------------------------------------------------
module mte_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [3:0]      channel,
  input  mte_pkg::q_out_t qin,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic [31:0]     out_track_length
);

  logic            busy_r, busy_nxt;
  mte_pkg::entry_t ent_r, ent_nxt;
  logic [2:0]      idx_r, idx_nxt;
  logic [mte_pkg::DLY_BITS-1:0] sh_r, sh_nxt;
  logic [31:0]     cnt_r, cnt_nxt;
  logic            ov_r, ov_nxt;
  logic [7:0]      ob_r, ob_nxt;
  logic            ol_r, ol_nxt;
  logic [31:0]     olen_r, olen_nxt;

  logic       adv;
  logic       is_last;
  logic [7:0] cur_byte;
  logic [31:0] cur_len;

  assign adv = busy_r && (!ov_r || out_ready);

  always_comb begin
    cur_len = '0;
    if (ent_r.cmd == mte_pkg::CMD_EOT) begin
      is_last = (idx_r == mte_pkg::EOT_LAST_IDX);
      unique case (idx_r)
        3'd0:    cur_byte = mte_pkg::ZERO_BYTE;
        3'd1:    cur_byte = mte_pkg::META_PREFIX;
        3'd2:    cur_byte = mte_pkg::META_EOT;
        default: cur_byte = mte_pkg::ZERO_BYTE;
      endcase
      if (is_last) begin
        cur_len = cnt_r + 32'd1;
      end
    end else begin
      is_last = (idx_r == 3'(ent_r.ngrp + 3'd2));
      if (idx_r < ent_r.ngrp) begin
        cur_byte = {idx_r != 3'(ent_r.ngrp - 3'd1),
                    sh_r[mte_pkg::DLY_BITS-1 -: mte_pkg::GRP_BITS]};
      end else if (idx_r == ent_r.ngrp) begin
        cur_byte = {1'b1, 2'b00, ent_r.is_on, channel};
      end else if (is_last) begin
        cur_byte = {1'b0, ent_r.vel};
      end else begin
        cur_byte = {1'b0, ent_r.key};
      end
    end
  end

  assign q_pop = qin.valid && (!busy_r || (adv && is_last));

  always_comb begin
    busy_nxt = busy_r;
    ent_nxt  = ent_r;
    idx_nxt  = idx_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    ov_nxt   = ov_r;
    ob_nxt   = ob_r;
    ol_nxt   = ol_r;
    olen_nxt = olen_r;
    if (out_ready) begin
      ov_nxt = 1'b0;
    end
    if (adv) begin
      ov_nxt   = 1'b1;
      ob_nxt   = cur_byte;
      ol_nxt   = is_last;
      olen_nxt = cur_len;
      idx_nxt  = idx_r + 3'd1;
      sh_nxt   = sh_r << mte_pkg::GRP_BITS;
      if (is_last && ent_r.cmd == mte_pkg::CMD_EOT) begin
        cnt_nxt = '0;
      end else begin
        cnt_nxt = cnt_r + 32'd1;
      end
      if (is_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      busy_nxt = 1'b1;
      ent_nxt  = qin.data;
      idx_nxt  = '0;
      sh_nxt   = qin.data.dly;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      cnt_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      cnt_r  <= cnt_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r  <= ent_nxt;
    sh_r   <= sh_nxt;
    ob_r   <= ob_nxt;
    ol_r   <= ol_nxt;
    olen_r <= olen_nxt;
  end

  assign out_valid        = ov_r;
  assign out_byte         = ob_r;
  assign out_last         = ol_r;
  assign out_track_length = olen_r;

  a_len_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !ol_r |-> olen_r == 32'd0)
    else $error("track length on non-final byte");
  a_eot_clears_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    adv && is_last && ent_r.cmd == mte_pkg::CMD_EOT |=> cnt_r == 32'd0)
    else $error("byte count not cleared after end of track");
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && ent_r.cmd == mte_pkg::CMD_NOTE |-> idx_r <= 3'(ent_r.ngrp + 3'd2))
    else $error("byte index past end of event");
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r && $stable(ob_r))
    else $error("output byte changed under stall");

endmodule

### hw/rtl/midi_track_event_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_track_event_encoder_top
// Encodes note events into MIDI track chunk body bytes with VLQ deltas.
// ----------------------------------------------------------------------------
//  Channel  Handshake            Payload
//  in       in_valid/in_ready    in_cmd, in_event_tick, in_note_key,
//                                in_note_velocity, in_is_on
//  out      out_valid/out_ready  out_byte, out_last, out_track_length
//  cfg      cfg_we               cfg_wdata (MIDI channel)
//
//  One byte leaves per cycle unless out_ready stalls (single byte port):
//  a note event is 4 to 8 bytes (VLQ length plus three), end of track 4.
//  A four-entry request queue lets the front accept while bytes drain.
//  Reset is synchronous (rst_n low): clears tick, byte count and queue.
//  Either side may stall freely; the output register holds under stall.
// ----------------------------------------------------------------------------
module midi_track_event_encoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [31:0] in_event_tick,
  input  logic [6:0]  in_note_key,
  input  logic [6:0]  in_note_velocity,
  input  logic        in_is_on,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [31:0] out_track_length
);

  logic [3:0]      channel_r, channel_nxt;
  logic            q_full, q_push, q_pop;
  mte_pkg::entry_t q_din;
  mte_pkg::q_out_t q_out;

  assign channel_nxt = cfg_we ? cfg_wdata : channel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_r <= '0;
    end else begin
      channel_r <= channel_nxt;
    end
  end

  mte_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_event_tick    (in_event_tick),
    .in_note_key      (in_note_key),
    .in_note_velocity (in_note_velocity),
    .in_is_on         (in_is_on),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_din)
  );

  mte_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .qout  (q_out)
  );

  mte_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .channel          (channel_r),
    .qin              (q_out),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last         (out_last),
    .out_track_length (out_track_length)
  );

endmodule

### tb/midi_track_event_encoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_track_event_encoder_top_tb
// Self-checking bench for the MIDI track event encoder. Note and end-of-track
// requests are sent over the in_ channel. Each accepted request is encoded
// by a local model (VLQ delta, status, key, velocity, or the end marker with
// the track length), and the expected bytes are compared field by field with
// every byte taken from the out_ channel. Directed cases cover VLQ group
// boundaries, tick wrap, channel extremes and empty tracks. A long receiver
// hold fills the block's queue. Random tracks follow, with bursty sending
// and several receiver stall patterns.
// ----------------------------------------------------------------------------
module midi_track_event_encoder_top_tb;

  localparam int CLK_PERIOD   = 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE       = 8;
  localparam int RANDOM_ITEMS = 420;
  localparam int HOLD_CYCLES  = 300;

  localparam logic [3:0] NOTE_ON_HI  = 4'h9;
  localparam logic [3:0] NOTE_OFF_HI = 4'h8;
  localparam logic [7:0] VLQ_MORE    = 8'h80;
  localparam logic [7:0] GRP_MASK    = 8'h7F;

  localparam int RX_FREE    = 0;
  localparam int RX_RANDOM  = 1;
  localparam int RX_PATTERN = 2;
  localparam int RX_SPARSE  = 3;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    logic [31:0] track_len;
  } enc_byte_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        in_cmd;
  logic [31:0] in_event_tick;
  logic [6:0]  in_note_key;
  logic [6:0]  in_note_velocity;
  logic        in_is_on;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [31:0] out_track_length;

  enc_byte_t   bytes_due[$];
  enc_byte_t   due;
  logic [3:0]  midi_channel;
  logic [31:0] prev_tick;
  logic [31:0] body_count;

  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          hold_len = 0;
  int          rx_mode = RX_FREE;
  int          rx_phase = 0;
  int          burst_left = 0;
  int          gap_max = 6;
  int          burst_max = 10;
  bit          tx_steady = 1'b0;

  midi_track_event_encoder_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_event_tick    (in_event_tick),
    .in_note_key      (in_note_key),
    .in_note_velocity (in_note_velocity),
    .in_is_on         (in_is_on),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last         (out_last),
    .out_track_length (out_track_length)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d bytes still due", $time, bytes_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void push_due(logic [7:0] data, logic last, logic [31:0] len);
    enc_byte_t e;
    e.data      = data;
    e.last      = last;
    e.track_len = len;
    bytes_due.push_back(e);
  endfunction

  function automatic void encode_request(logic cmd, logic [31:0] tick,
                                         logic [6:0] key, logic [6:0] vel, logic on);
    logic [31:0] delta;
    logic [7:0]  grp;
    int          ngrp;
    int          g;
    if (cmd == mte_pkg::CMD_EOT) begin
      push_due(mte_pkg::ZERO_BYTE, 1'b0, 32'd0);
      push_due(mte_pkg::META_PREFIX, 1'b0, 32'd0);
      push_due(mte_pkg::META_EOT, 1'b0, 32'd0);
      push_due(mte_pkg::ZERO_BYTE, 1'b1, body_count + 32'd4);
      prev_tick  = 32'd0;
      body_count = 32'd0;
    end else begin
      delta = tick - prev_tick;
      ngrp  = 1;
      for (g = 1; g < mte_pkg::MAX_GRPS; g++) begin
        if ((delta >> (mte_pkg::GRP_BITS * g)) != 0) ngrp = g + 1;
      end
      for (g = ngrp - 1; g >= 0; g--) begin
        grp = 8'(delta >> (mte_pkg::GRP_BITS * g)) & GRP_MASK;
        push_due((g != 0) ? (grp | VLQ_MORE) : grp, 1'b0, 32'd0);
      end
      push_due({on ? NOTE_ON_HI : NOTE_OFF_HI, midi_channel}, 1'b0, 32'd0);
      push_due({1'b0, key}, 1'b0, 32'd0);
      push_due({1'b0, vel}, 1'b1, 32'd0);
      prev_tick  = tick;
      body_count = body_count + 32'(ngrp + 3);
    end
  endfunction

  // Result checker and request predictor, both sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (bytes_due.size() == 0) begin
          $display("%0t: unexpected byte: expected none, actual %02h last %0b len %0d",
                   $time, out_byte, out_last, out_track_length);
          mismatch_count++;
        end else begin
          due = bytes_due.pop_front();
          if (out_byte !== due.data) begin
            $display("%0t: out_byte expected %02h actual %02h",
                     $time, due.data, out_byte);
            mismatch_count++;
          end
          if (out_last !== due.last) begin
            $display("%0t: out_last expected %0b actual %0b",
                     $time, due.last, out_last);
            mismatch_count++;
          end
          if (out_track_length !== due.track_len) begin
            $display("%0t: out_track_length expected %0d actual %0d",
                     $time, due.track_len, out_track_length);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready)
        encode_request(in_cmd, in_event_tick, in_note_key, in_note_velocity, in_is_on);
    end
  end

  // Receiver: long hold when asked, otherwise the current stall pattern
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_phase = rx_phase + 1;
      if (hold_len != 0) begin
        out_ready = 1'b0;
        hold_len  = hold_len - 1;
      end else begin
        case (rx_mode)
          RX_RANDOM:  out_ready = ($urandom_range(0, 99) >= 35);
          RX_PATTERN: out_ready = ((rx_phase % 7) < 4);
          RX_SPARSE:  out_ready = ($urandom_range(0, 4) == 0);
          default:    out_ready = 1'b1;
        endcase
      end
    end
  end

  task automatic send_request(logic cmd, logic [31:0] tick, logic [6:0] key,
                              logic [6:0] vel, logic on);
    @(negedge clk);
    in_cmd           = cmd;
    in_event_tick    = tick;
    in_note_key      = key;
    in_note_velocity = vel;
    in_is_on         = on;
    in_valid         = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Bursts with random gaps; a steady sender never drops valid
  task automatic pace();
    if (tx_steady) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, gap_max)) @(negedge clk);
      burst_left = $urandom_range(0, burst_max);
    end
  endtask

  task automatic send_note(logic [31:0] tick, logic [6:0] key, logic [6:0] vel, logic on);
    send_request(mte_pkg::CMD_NOTE, tick, key, vel, on);
    pace();
  endtask

  task automatic send_eot();
    send_request(mte_pkg::CMD_EOT, $urandom, 7'($urandom_range(0, 127)),
                 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
    pace();
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (bytes_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_channel(logic [3:0] ch);
    wait_idle();
    cfg_wdata    = ch;
    cfg_we       = 1'b1;
    midi_channel = ch;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic test_reset_state();
    send_eot();
    send_note(32'd0, 7'd0, 7'd0, 1'b0);
    send_eot();
  endtask

  task automatic test_vlq_lengths();
    logic [31:0] tick;
    tick = 32'd127;
    send_note(tick, 7'd127, 7'd127, 1'b1);
    tick = tick + 32'd128;
    send_note(tick, 7'd0, 7'd127, 1'b0);
    tick = tick + 32'd16383;
    send_note(tick, 7'd127, 7'd0, 1'b1);
    tick = tick + 32'd16384;
    send_note(tick, 7'h55, 7'h2A, 1'b0);
    tick = tick + 32'd2097151;
    send_note(tick, 7'h2A, 7'h55, 1'b1);
    tick = tick + 32'd2097152;
    send_note(tick, 7'd60, 7'd100, 1'b0);
    tick = tick + 32'd268435455;
    send_note(tick, 7'd61, 7'd1, 1'b1);
    tick = tick + 32'd268435456;
    send_note(tick, 7'd62, 7'd126, 1'b0);
    send_note(32'hFFFF_FFFF, 7'd127, 7'd127, 1'b1);
    send_eot();
  endtask

  task automatic test_tick_wrap();
    send_note(32'd100, 7'd64, 7'd90, 1'b1);
    send_note(32'd50, 7'd64, 7'd0, 1'b0);
    send_note(32'd50, 7'd65, 7'd80, 1'b1);
    send_eot();
  endtask

  task automatic test_channel_extremes();
    set_channel(4'd15);
    send_note(32'd1, 7'd36, 7'd120, 1'b1);
    send_note(32'd129, 7'd36, 7'd0, 1'b0);
    send_eot();
    set_channel(4'd0);
  endtask

  // Receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    int i;
    wait_idle();
    rx_mode = RX_FREE;
    @(posedge clk);
    hold_len  = HOLD_CYCLES;
    tx_steady = 1'b1;
    for (i = 0; i < 16; i++)
      send_note(32'(i * 300), 7'(i), 7'(127 - i), 1'(i));
    send_eot();
    tx_steady = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_tracks();
    int          sent;
    int          n_ev;
    int          pick;
    logic [31:0] tick;
    sent = 0;
    tick = 32'd0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        pick = $urandom_range(0, 3);
        set_channel(pick == 0 ? 4'd0 : pick == 1 ? 4'd15 : 4'($urandom_range(0, 15)));
      end
      rx_mode   = $urandom_range(RX_FREE, RX_SPARSE);
      tx_steady = ($urandom_range(0, 4) == 0);
      gap_max   = $urandom_range(1, 12);
      burst_max = $urandom_range(0, 15);
      n_ev      = $urandom_range(1, 24);
      repeat (n_ev) begin
        pick = $urandom_range(0, 99);
        if (pick < 20)      tick = tick;
        else if (pick < 60) tick = tick + $urandom_range(1, 127);
        else if (pick < 78) tick = tick + $urandom_range(128, 16383);
        else if (pick < 88) tick = tick + $urandom_range(16384, 2097151);
        else if (pick < 94) tick = tick + $urandom_range(2097152, 32'h0FFF_FFFF);
        else                tick = $urandom;
        send_note(tick, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                  1'($urandom_range(0, 1)));
        sent++;
      end
      if ($urandom_range(0, 9) != 0) begin
        send_eot();
        tick = 32'd0;
        sent++;
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = 4'd0;
    in_valid         = 1'b0;
    in_cmd           = mte_pkg::CMD_NOTE;
    in_event_tick    = 32'd0;
    in_note_key      = 7'd0;
    in_note_velocity = 7'd0;
    in_is_on         = 1'b0;
    midi_channel     = 4'd0;
    prev_tick        = 32'd0;
    body_count       = 32'd0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    rx_mode = RX_RANDOM;
    test_reset_state();
    test_vlq_lengths();
    test_tick_wrap();
    test_channel_extremes();
    test_backpressure();
    test_random_tracks();
    wait_idle();

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
